FILE: design/lrs_pkg.sv
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types, constants and helpers of the line raster stepper.
// ----------------------------------------------------------------------------
package lrs_pkg;

  localparam int GridDim = 64;
  localparam int CoordW  = 6;
  localparam int AccW    = CoordW + 1;

  localparam logic [CoordW-1:0] MaxCoord = CoordW'(GridDim - 1);

  typedef struct packed {
    logic capture;
    logic setup;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic last_step;
  } status_t;

  function automatic logic [CoordW-1:0] clamp_coord(input logic [CoordW-1:0] c);
    clamp_coord = (c > MaxCoord) ? MaxCoord : c;
  endfunction

  function automatic logic [CoordW-1:0] move_coord(input logic [CoordW-1:0] c,
                                                   input logic              mv,
                                                   input logic              neg);
    logic [CoordW-1:0] r;
    r = c;
    if (mv) begin
      r = neg ? c - CoordW'(1) : c + CoordW'(1);
    end
    move_coord = r;
  endfunction

endpackage

FILE: design/lrs_ctrl.sv
// ----------------------------------------------------------------------------
// lrs_ctrl
// Sequencer: capture, a setup state, then one step per point.
// ----------------------------------------------------------------------------
module lrs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  lrs_pkg::status_t status_i,
  output lrs_pkg::cmd_t    cmd_o,
  output logic            busy_o
);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StSetup = 3'b010,
    StRun   = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.setup   = 1'b0;
    cmd_o.step    = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StSetup;
        end
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
        state_d     = StRun;
      end
      StRun: begin
        cmd_o.step = 1'b1;
        if (status_i.last_step) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/lrs_datapath.sv
// ----------------------------------------------------------------------------
// lrs_datapath
// Coordinate, delta and error registers; one grid point per step command.
// ----------------------------------------------------------------------------
module lrs_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lrs_pkg::cmd_t              cmd_i,
  input  logic [lrs_pkg::CoordW-1:0] start_col_i,
  input  logic [lrs_pkg::CoordW-1:0] start_row_i,
  input  logic [lrs_pkg::CoordW-1:0] end_col_i,
  input  logic [lrs_pkg::CoordW-1:0] end_row_i,
  output lrs_pkg::status_t           status_o,
  output logic [lrs_pkg::CoordW-1:0] point_col_o,
  output logic [lrs_pkg::CoordW-1:0] point_row_o,
  output logic                       last_point_o,
  output logic                       point_strobe_o
);

  logic [lrs_pkg::CoordW-1:0] cur_col_q, cur_row_q, end_col_q, end_row_q;
  logic [lrs_pkg::CoordW-1:0] major_q, minor_q, rem_q;
  logic [lrs_pkg::AccW-1:0]   acc_q;
  logic col_neg_q, row_neg_q, col_nz_q, row_nz_q, col_major_q;
  logic [lrs_pkg::CoordW-1:0] out_col_q, out_row_q;
  logic                       out_last_q, strobe_q;

  // setup terms
  logic                       col_neg, row_neg, col_major;
  logic [lrs_pkg::CoordW-1:0] acol, arow, major_d;

  // step terms
  logic [lrs_pkg::AccW-1:0]   acc_sum;
  logic                       diag, mv_col, mv_row;

  assign col_neg   = (end_col_q < cur_col_q);
  assign row_neg   = (end_row_q < cur_row_q);
  assign acol      = col_neg ? cur_col_q - end_col_q : end_col_q - cur_col_q;
  assign arow      = row_neg ? cur_row_q - end_row_q : end_row_q - cur_row_q;
  assign col_major = (acol > arow);
  assign major_d   = col_major ? acol : arow;

  assign acc_sum = acc_q + lrs_pkg::AccW'(minor_q);
  assign diag    = (acc_sum >= lrs_pkg::AccW'(major_q));
  assign mv_col  = diag ? col_nz_q : col_major_q;
  assign mv_row  = diag ? row_nz_q : !col_major_q && row_nz_q;

  assign status_o.last_step = (rem_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cur_col_q <= lrs_pkg::clamp_coord(start_col_i);
      cur_row_q <= lrs_pkg::clamp_coord(start_row_i);
      end_col_q <= lrs_pkg::clamp_coord(end_col_i);
      end_row_q <= lrs_pkg::clamp_coord(end_row_i);
    end else if (cmd_i.setup) begin
      col_neg_q   <= col_neg;
      row_neg_q   <= row_neg;
      col_nz_q    <= (acol != '0);
      row_nz_q    <= (arow != '0);
      col_major_q <= col_major;
      major_q     <= major_d;
      minor_q     <= col_major ? arow : acol;
      rem_q       <= major_d;
      acc_q       <= lrs_pkg::AccW'(major_d >> 1);
    end else if (cmd_i.step) begin
      out_col_q  <= cur_col_q;
      out_row_q  <= cur_row_q;
      out_last_q <= (rem_q == '0);
      acc_q      <= diag ? acc_sum - lrs_pkg::AccW'(major_q) : acc_sum;
      cur_col_q  <= lrs_pkg::move_coord(cur_col_q, mv_col, col_neg_q);
      cur_row_q  <= lrs_pkg::move_coord(cur_row_q, mv_row, row_neg_q);
      rem_q      <= rem_q - lrs_pkg::CoordW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.step;
    end
  end

  assign point_col_o    = out_col_q;
  assign point_row_o    = out_row_q;
  assign last_point_o   = out_last_q;
  assign point_strobe_o = strobe_q;

endmodule

FILE: design/line_raster_stepper_unit.sv
// ----------------------------------------------------------------------------
// line_raster_stepper_unit
// Bresenham line stepper for all octants: emits every grid point of a line.
// ----------------------------------------------------------------------------
// channel  | transfer when          | ports
// request  | start && !busy         | start_col_i, start_row_i, end_col_i, end_row_i
// point    | point_strobe_o         | point_col_o, point_row_o, last_point_o
//
// A request passes through a setup state, then yields one point per cycle until
// busy drops after the last one. Points come out of a register in the cycle
// after their step. The receiver cannot stall; each point is shown for one
// cycle. Reset returns the sequencer to idle.
// ----------------------------------------------------------------------------
module line_raster_stepper_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [lrs_pkg::CoordW-1:0] start_col_i,
  input  logic [lrs_pkg::CoordW-1:0] start_row_i,
  input  logic [lrs_pkg::CoordW-1:0] end_col_i,
  input  logic [lrs_pkg::CoordW-1:0] end_row_i,
  output logic [lrs_pkg::CoordW-1:0] point_col_o,
  output logic [lrs_pkg::CoordW-1:0] point_row_o,
  output logic                       last_point_o,
  output logic                       point_strobe_o
);

  lrs_pkg::cmd_t    cmd;
  lrs_pkg::status_t status;

  lrs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  lrs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .start_col_i    (start_col_i),
    .start_row_i    (start_row_i),
    .end_col_i      (end_col_i),
    .end_row_i      (end_row_i),
    .status_o       (status),
    .point_col_o    (point_col_o),
    .point_row_o    (point_row_o),
    .last_point_o   (last_point_o),
    .point_strobe_o (point_strobe_o)
  );

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for line_raster_stepper_unit. Line requests come from a
// queue. The driver sends them over the start/busy handshake and varies the
// idle gaps between requests. Each accepted request is traced by a local
// Bresenham model into a queue of expected grid points. The monitor checks
// every strobed point against that queue, field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW        = lrs_pkg::CoordW;
  localparam int MaxC      = lrs_pkg::GridDim - 1;
  localparam int NumRandom = 400;
  localparam int IdleLimit = 2000;

  typedef struct packed {
    logic [CW-1:0] scol;
    logic [CW-1:0] srow;
    logic [CW-1:0] ecol;
    logic [CW-1:0] erow;
  } line_req_t;

  typedef struct packed {
    logic [CW-1:0] col;
    logic [CW-1:0] row;
    logic          last;
  } grid_point_t;

  logic          clk_i  = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start  = 1'b0;
  logic          busy;
  logic [CW-1:0] start_col_i = '0;
  logic [CW-1:0] start_row_i = '0;
  logic [CW-1:0] end_col_i   = '0;
  logic [CW-1:0] end_row_i   = '0;
  logic [CW-1:0] point_col_o;
  logic [CW-1:0] point_row_o;
  logic          last_point_o;
  logic          point_strobe_o;

  line_req_t   pending_lines[$];
  grid_point_t expected_points[$];
  int          total_lines;
  int          lines_sent   = 0;
  int          points_seen  = 0;
  int          error_count  = 0;
  int          idle_cycles  = 0;
  int          idle_pct_tbl[4] = '{0, 65, 0, 35};

  line_raster_stepper_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .start_col_i    (start_col_i),
    .start_row_i    (start_row_i),
    .end_col_i      (end_col_i),
    .end_row_i      (end_row_i),
    .point_col_o    (point_col_o),
    .point_row_o    (point_row_o),
    .last_point_o   (last_point_o),
    .point_strobe_o (point_strobe_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void trace_line(input line_req_t req);
    int          dc, dr, ac, ar, sc, sr, major, minor, acc, c, r;
    bit          col_major;
    grid_point_t p;
    dc = int'(req.ecol) - int'(req.scol);
    dr = int'(req.erow) - int'(req.srow);
    sc = (dc > 0) ? 1 : ((dc < 0) ? -1 : 0);
    sr = (dr > 0) ? 1 : ((dr < 0) ? -1 : 0);
    ac = (dc < 0) ? -dc : dc;
    ar = (dr < 0) ? -dr : dr;
    col_major = (ac > ar);
    major = col_major ? ac : ar;
    minor = col_major ? ar : ac;
    acc = major >> 1;
    c = int'(req.scol);
    r = int'(req.srow);
    for (int i = 0; i <= major; i++) begin
      p.col  = CW'(c);
      p.row  = CW'(r);
      p.last = (i == major);
      expected_points.push_back(p);
      acc += minor;
      if (acc >= major) begin
        acc -= major;
        c += sc;
        r += sr;
      end else if (col_major) begin
        c += sc;
      end else begin
        r += sr;
      end
    end
  endfunction

  function automatic void add_line(input int c0, input int r0, input int c1, input int r1);
    line_req_t req;
    req.scol = CW'(c0);
    req.srow = CW'(r0);
    req.ecol = CW'(c1);
    req.erow = CW'(r1);
    pending_lines.push_back(req);
  endfunction

  function automatic int near_coord(input int base);
    int v;
    v = base + $urandom_range(14) - 7;
    if (v < 0) v = 0;
    if (v > MaxC) v = MaxC;
    return v;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    int        phase;
    line_req_t req;
    if (!rst_ni) begin
      start       <= 1'b0;
      start_col_i <= '0;
      start_row_i <= '0;
      end_col_i   <= '0;
      end_row_i   <= '0;
    end else begin
      if (start && !busy) begin
        trace_line({start_col_i, start_row_i, end_col_i, end_row_i});
        lines_sent++;
      end
      if (!start || !busy) begin
        phase = (lines_sent * 4) / total_lines;
        if (phase > 3) phase = 3;
        if (pending_lines.size() > 0 && $urandom_range(99) >= idle_pct_tbl[phase]) begin
          req = pending_lines.pop_front();
          start       <= 1'b1;
          start_col_i <= req.scol;
          start_row_i <= req.srow;
          end_col_i   <= req.ecol;
          end_row_i   <= req.erow;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // point monitor and watchdog
  always @(posedge clk_i) begin
    grid_point_t exp_p;
    if (rst_ni) begin
      if (point_strobe_o) begin
        points_seen++;
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("unexpected point (%0d,%0d) last=%0b",
                                    point_col_o, point_row_o, last_point_o));
        end else begin
          exp_p = expected_points.pop_front();
          if (point_col_o !== exp_p.col)
            report_mismatch($sformatf("point_col %0d, want %0d", point_col_o, exp_p.col));
          if (point_row_o !== exp_p.row)
            report_mismatch($sformatf("point_row %0d, want %0d", point_row_o, exp_p.row));
          if (last_point_o !== exp_p.last)
            report_mismatch($sformatf("last_point %0b, want %0b", last_point_o, exp_p.last));
        end
      end
      if (point_strobe_o || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("watchdog: no transfer for %0d cycles", IdleLimit);
          $display("line_raster_stepper_unit verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int c0, r0;
    // single point, corners
    add_line(0, 0, 0, 0);
    add_line(63, 63, 63, 63);
    add_line(0, 63, 0, 63);
    // full-length axis lines, both directions
    add_line(0, 0, 63, 0);
    add_line(63, 63, 0, 63);
    add_line(0, 0, 0, 63);
    add_line(63, 63, 63, 0);
    // tied deltas, full diagonals
    add_line(0, 0, 63, 63);
    add_line(63, 0, 0, 63);
    add_line(63, 63, 0, 0);
    add_line(0, 63, 63, 0);
    add_line(10, 10, 13, 13);
    // all eight octants
    add_line(20, 20, 30, 24);
    add_line(20, 20, 24, 30);
    add_line(20, 20, 16, 30);
    add_line(20, 20, 10, 24);
    add_line(20, 20, 10, 16);
    add_line(20, 20, 16, 10);
    add_line(20, 20, 24, 10);
    add_line(20, 20, 30, 16);
    // near and exact ties, shallow lines
    add_line(0, 0, 63, 62);
    add_line(42, 21, 21, 42);
    add_line(5, 40, 60, 41);
    add_line(1, 2, 2, 1);
    for (int i = 0; i < NumRandom; i++) begin
      c0 = $urandom_range(MaxC);
      r0 = $urandom_range(MaxC);
      if ($urandom_range(2) == 0)
        add_line(c0, r0, $urandom_range(MaxC), $urandom_range(MaxC));
      else
        add_line(c0, r0, near_coord(c0), near_coord(r0));
    end
    total_lines = pending_lines.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_lines.size() > 0 || start || lines_sent < total_lines ||
           expected_points.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (expected_points.size() > 0)
      report_mismatch($sformatf("%0d expected points never arrived", expected_points.size()));

    $display("ran %0d line requests over four idle phases, %0d grid points checked",
             lines_sent, points_seen);
    if (error_count == 0) begin
      $display("line_raster_stepper_unit verification clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("line_raster_stepper_unit verification failed");
    end
    $finish;
  end

endmodule
